// ----- hw/rtl/pdc_pkg.sv -----
// Shared types and constants of the x86 16-bit instruction predecoder.
// Holds the opcode operand template, the opcode and ModRM codes, and the
// record that travels from the length finder to the flag decoder.
`default_nettype none

package pdc_pkg;

	// Record of one finished instruction
	typedef struct packed {
		logic [4:0] len;
		logic [3:0] prefix;
		logic [7:0] opcode;
		logic [2:0] reg_f;
	} instr_rec_t;

	// Write side of the instruction queue
	typedef struct packed {
		logic       valid;
		instr_rec_t rec;
	} q_wr_t;

	// Head of the instruction queue
	typedef struct packed {
		logic       valid;
		instr_rec_t rec;
	} q_head_t;

	// Depth of the queue between the length finder and the flag decoder
	localparam int unsigned QUEUE_DEPTH = 4;

	// Operand template: high nibble is the ModRM kind, low nibble the fixed extra bytes
	localparam logic [7:0] K_NONE = 8'h00;
	localparam logic [7:0] K_M    = 8'h10;
	localparam logic [7:0] K_G1   = 8'h20;
	localparam logic [7:0] K_G3   = 8'h30;

	localparam logic [7:0] OP_SHAPE [256] = '{
		K_M, K_M, K_M, K_M, 8'd1, 8'd2, 8'd0, 8'd0,
		K_M, K_M, K_M, K_M, 8'd1, 8'd2, 8'd0, 8'd0,
		K_M, K_M, K_M, K_M, 8'd1, 8'd2, 8'd0, 8'd0,
		K_M, K_M, K_M, K_M, 8'd1, 8'd2, 8'd0, 8'd0,
		K_M, K_M, K_M, K_M, 8'd1, 8'd2, 8'd0, 8'd0,
		K_M, K_M, K_M, K_M, 8'd1, 8'd2, 8'd0, 8'd0,
		K_M, K_M, K_M, K_M, 8'd1, 8'd2, 8'd0, 8'd0,
		K_M, K_M, K_M, K_M, 8'd1, 8'd2, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, K_M, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd2, K_M + 8'd2, 8'd1, K_M + 8'd1, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		K_G1, K_G1, K_G1, K_G1, K_M, K_M, K_M, K_M,
		K_M, K_M, K_M, K_M, K_M, K_M, K_M, K_M,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd2, 8'd2, 8'd2, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd1, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
		K_M + 8'd1, K_M + 8'd1, 8'd2, 8'd0, K_M, K_M, K_M + 8'd1, K_M + 8'd2,
		8'd3, 8'd0, 8'd2, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0,
		K_M, K_M, K_M, K_M, 8'd1, 8'd1, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd2, 8'd2, 8'd4, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, K_G3, K_G3,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, K_M, K_M
	};

	// Prefix bytes
	localparam logic [7:0] PFX_LOCK  = 8'hF0;
	localparam logic [7:0] PFX_REPNE = 8'hF2;
	localparam logic [7:0] PFX_REP   = 8'hF3;
	localparam logic [7:0] PFX_ES    = 8'h26;
	localparam logic [7:0] PFX_CS    = 8'h2E;
	localparam logic [7:0] PFX_SS    = 8'h36;
	localparam logic [7:0] PFX_DS    = 8'h3E;

	// ModRM codes
	localparam logic [1:0] MOD_MEM    = 2'd0;
	localparam logic [1:0] MOD_DISP8  = 2'd1;
	localparam logic [1:0] MOD_DISP16 = 2'd2;
	localparam logic [2:0] RM_DIRECT  = 3'd6;

	// Group sub-operation codes (ModRM reg field)
	localparam logic [2:0] G3_REG_TEST   = 3'd0;
	localparam logic [2:0] G3_REG_UNDEF  = 3'd1;
	localparam logic [2:0] G5_REG_CALL   = 3'd2;
	localparam logic [2:0] G5_REG_CALLF  = 3'd3;
	localparam logic [2:0] G5_REG_JMP    = 3'd4;
	localparam logic [2:0] G5_REG_JMPF   = 3'd5;
	localparam logic [2:0] SHF_REG_UNDEF = 3'd6;
	localparam logic [2:0] G5_REG_UNDEF  = 3'd7;

	// Opcodes
	localparam logic [7:0] OP_CALL_FAR  = 8'h9A;
	localparam logic [7:0] OP_CALL_NEAR = 8'hE8;
	localparam logic [7:0] OP_JMP_NEAR  = 8'hE9;
	localparam logic [7:0] OP_JMP_FAR   = 8'hEA;
	localparam logic [7:0] OP_JMP_SHORT = 8'hEB;
	localparam logic [7:0] OP_RET_IMM   = 8'hC2;
	localparam logic [7:0] OP_RET       = 8'hC3;
	localparam logic [7:0] OP_RETF_IMM  = 8'hCA;
	localparam logic [7:0] OP_RETF      = 8'hCB;
	localparam logic [7:0] OP_IRET      = 8'hCF;
	localparam logic [7:0] OP_GRP4      = 8'hFE;
	localparam logic [7:0] OP_GRP5      = 8'hFF;
	localparam logic [7:0] OP_GRP3_B    = 8'hF6;
	localparam logic [7:0] OP_GRP3_W    = 8'hF7;
	localparam logic [7:0] OP_SHF_IMM_B = 8'hC0;
	localparam logic [7:0] OP_SHF_IMM_W = 8'hC1;
	localparam logic [7:0] OP_SHF_1_B   = 8'hD0;
	localparam logic [7:0] OP_SHF_1_W   = 8'hD1;
	localparam logic [7:0] OP_SHF_CL_B  = 8'hD2;
	localparam logic [7:0] OP_SHF_CL_W  = 8'hD3;
	localparam logic [7:0] OP_JCC_FIRST  = 8'h70;
	localparam logic [7:0] OP_JCC_LAST   = 8'h7F;
	localparam logic [7:0] OP_LOOP_FIRST = 8'hE0;
	localparam logic [7:0] OP_LOOP_LAST  = 8'hE3;
	localparam logic [7:0] OP_ESC_FIRST  = 8'hD8;
	localparam logic [7:0] OP_ESC_LAST   = 8'hDF;
	localparam logic [7:0] OP_UNDEF_0F   = 8'h0F;
	localparam logic [7:0] OP_UNDEF_LO   = 8'h63;
	localparam logic [7:0] OP_UNDEF_HI   = 8'h67;
	localparam logic [7:0] OP_UNDEF_F1   = 8'hF1;

endpackage

`default_nettype wire

// ----- hw/rtl/pdc_front.sv -----
// Length finder of the predecoder: walks the byte stream and finds ends.
// Counts prefixes, follows the operand template and ModRM displacement,
// and writes one record per finished instruction. Depends on pdc_pkg.
`default_nettype none

module pdc_front #(
	parameter int PREFIX_LIMIT = 15
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                take,
	input  wire  [7:0]         code_byte,
	input  wire                restart,
	output pdc_pkg::q_wr_t     wr
);

	typedef enum logic [2:0] {
		PH_START = 3'b001,
		PH_MODRM = 3'b010,
		PH_TAIL  = 3'b100
	} phase_t;

	phase_t     phase_q,  eff_phase,  nxt_phase;
	logic [3:0] prefix_q, eff_prefix, nxt_prefix;
	logic [7:0] opcode_q, eff_opcode, nxt_opcode;
	logic [2:0] reg_q,    eff_reg,    nxt_reg;
	logic [2:0] rem_q,    eff_rem,    nxt_rem;
	logic [4:0] len_q,    eff_len,    nxt_len;
	logic [4:0] len_inc;
	logic [7:0] shape_cur, shape_held;
	logic [3:0] extra, grp_add;
	logic       is_prefix, emit;
	pdc_pkg::instr_rec_t rec;

	// Displacement bytes that follow a ModRM byte
	function automatic logic [3:0] disp_bytes(input logic [7:0] m);
		logic [1:0] mode;
		logic [2:0] rm;
		mode = m[7:6];
		rm   = m[2:0];
		if (mode == pdc_pkg::MOD_DISP16 ||
		    (mode == pdc_pkg::MOD_MEM && rm == pdc_pkg::RM_DIRECT)) begin
			disp_bytes = 4'd2;
		end else if (mode == pdc_pkg::MOD_DISP8) begin
			disp_bytes = 4'd1;
		end else begin
			disp_bytes = 4'd0;
		end
	endfunction

	// Decode the next state for the byte on the input
	always_comb begin
		eff_phase  = restart ? PH_START : phase_q;
		eff_prefix = restart ? 4'd0 : prefix_q;
		eff_opcode = restart ? 8'd0 : opcode_q;
		eff_reg    = restart ? 3'd0 : reg_q;
		eff_rem    = restart ? 3'd0 : rem_q;
		eff_len    = restart ? 5'd0 : len_q;
		len_inc    = eff_len + 5'd1;

		shape_cur  = pdc_pkg::OP_SHAPE[code_byte];
		shape_held = pdc_pkg::OP_SHAPE[eff_opcode];
		is_prefix  = code_byte inside {pdc_pkg::PFX_LOCK, pdc_pkg::PFX_REPNE,
			pdc_pkg::PFX_REP, pdc_pkg::PFX_ES, pdc_pkg::PFX_CS, pdc_pkg::PFX_SS,
			pdc_pkg::PFX_DS};

		nxt_phase  = eff_phase;
		nxt_prefix = eff_prefix;
		nxt_opcode = eff_opcode;
		nxt_reg    = eff_reg;
		nxt_rem    = eff_rem;
		nxt_len    = len_inc;
		grp_add    = 4'd0;
		extra      = 4'd0;
		emit       = 1'b0;

		case (eff_phase)
			PH_MODRM: begin
				nxt_reg = code_byte[5:3];
				if (shape_held[7:4] == pdc_pkg::K_G1[7:4]) begin
					grp_add = (eff_opcode[1:0] == 2'b01) ? 4'd2 : 4'd1;
				end else if (shape_held[7:4] == pdc_pkg::K_G3[7:4] &&
				             code_byte[5:3] == pdc_pkg::G3_REG_TEST) begin
					grp_add = eff_opcode[0] ? 4'd2 : 4'd1;
				end
				extra = disp_bytes(code_byte) + shape_held[3:0] + grp_add;
				if (extra == 4'd0) begin
					emit = 1'b1;
				end else begin
					nxt_phase = PH_TAIL;
					nxt_rem   = extra[2:0];
				end
			end
			PH_TAIL: begin
				nxt_rem = eff_rem - 3'd1;
				if (nxt_rem == 3'd0) begin
					emit = 1'b1;
				end
			end
			default: begin
				nxt_phase = PH_START;
				if (is_prefix && eff_prefix < 4'(PREFIX_LIMIT)) begin
					nxt_prefix = eff_prefix + 4'd1;
				end else begin
					nxt_opcode = code_byte;
					extra      = shape_cur[3:0];
					if (shape_cur[7:4] != pdc_pkg::K_NONE[7:4]) begin
						nxt_phase = PH_MODRM;
					end else if (extra == 4'd0) begin
						emit = 1'b1;
					end else begin
						nxt_phase = PH_TAIL;
						nxt_rem   = extra[2:0];
					end
				end
			end
		endcase

		// Capture the record before the state clears
		rec.len    = len_inc;
		rec.prefix = nxt_prefix;
		rec.opcode = nxt_opcode;
		rec.reg_f  = nxt_reg;

		// Start over after the last byte
		if (emit) begin
			nxt_phase  = PH_START;
			nxt_prefix = 4'd0;
			nxt_opcode = 8'd0;
			nxt_reg    = 3'd0;
			nxt_rem    = 3'd0;
			nxt_len    = 5'd0;
		end
	end

	// Advance on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			prefix_q <= 4'd0;
			opcode_q <= 8'd0;
			reg_q    <= 3'd0;
			rem_q    <= 3'd0;
			len_q    <= 5'd0;
		end else if (take) begin
			phase_q  <= nxt_phase;
			prefix_q <= nxt_prefix;
			opcode_q <= nxt_opcode;
			reg_q    <= nxt_reg;
			rem_q    <= nxt_rem;
			len_q    <= nxt_len;
		end
	end

	assign wr.valid = take && emit;
	assign wr.rec   = rec;

	a_tail_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_TAIL |-> rem_q != 3'd0)
		else $error("tail phase with no bytes left");

	a_prefix_limit: assert property (@(posedge clk) disable iff (!arst_n)
		prefix_q <= 4'(PREFIX_LIMIT))
		else $error("prefix count beyond limit");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr.valid |-> (wr.rec.len > {1'b0, wr.rec.prefix}) && (wr.rec.len <= 5'd21))
		else $error("instruction length out of range");

endmodule

`default_nettype wire

// ----- hw/rtl/pdc_fifo.sv -----
// Short queue of finished instruction records between the two halves.
// Register storage with read and write pointers. Depends on pdc_pkg.
`default_nettype none

module pdc_fifo (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire pdc_pkg::q_wr_t wr,
	input  wire                 rd,
	output pdc_pkg::q_head_t    head,
	output logic                full
);

	localparam int unsigned DEPTH = pdc_pkg::QUEUE_DEPTH;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	pdc_pkg::instr_rec_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.rec   = mem_q[rd_ptr_q];

	// Hold records
	always_ff @(posedge clk) begin
		if (wr.valid) begin
			mem_q[wr_ptr_q] <= wr.rec;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr.valid) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (wr.valid && !rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd && !wr.valid) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr.valid |-> !full)
		else $error("write into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> head.valid)
		else $error("read from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- hw/rtl/pdc_back.sv -----
// Flag decoder of the predecoder: takes records from the queue, derives
// the control-flow class flags and holds the result in an output register.
// Depends on pdc_pkg.
`default_nettype none

module pdc_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire pdc_pkg::q_head_t head,
	output logic                  rd,
	input  wire                   pop,
	output logic                  empty,
	output logic [4:0]            instr_length,
	output logic [3:0]            prefix_total,
	output logic [7:0]            opcode_value,
	output logic [2:0]            modrm_reg,
	output logic                  is_call,
	output logic                  is_uncond_jump,
	output logic                  is_cond_jump,
	output logic                  is_return,
	output logic                  is_undefined
);

	logic       out_valid_q;
	logic [7:0] op;
	logic [2:0] rg;
	logic       grp45, call, ret, ujmp, cjmp, undef;

	// Classify the record at the head of the queue
	always_comb begin
		op    = head.rec.opcode;
		rg    = head.rec.reg_f;
		grp45 = (op == pdc_pkg::OP_GRP4) || (op == pdc_pkg::OP_GRP5);
		call  = (op == pdc_pkg::OP_CALL_FAR) || (op == pdc_pkg::OP_CALL_NEAR) ||
			(grp45 && (rg == pdc_pkg::G5_REG_CALL || rg == pdc_pkg::G5_REG_CALLF));
		ret   = op inside {pdc_pkg::OP_RET_IMM, pdc_pkg::OP_RET, pdc_pkg::OP_RETF_IMM,
			pdc_pkg::OP_RETF, pdc_pkg::OP_IRET};
		ujmp  = call || ret || op inside {pdc_pkg::OP_JMP_NEAR, pdc_pkg::OP_JMP_FAR,
			pdc_pkg::OP_JMP_SHORT} ||
			(grp45 && (rg == pdc_pkg::G5_REG_JMP || rg == pdc_pkg::G5_REG_JMPF));
		cjmp  = op inside {[pdc_pkg::OP_JCC_FIRST : pdc_pkg::OP_JCC_LAST],
			[pdc_pkg::OP_LOOP_FIRST : pdc_pkg::OP_LOOP_LAST]};
		case (op)
			pdc_pkg::OP_SHF_IMM_B, pdc_pkg::OP_SHF_IMM_W, pdc_pkg::OP_SHF_1_B,
			pdc_pkg::OP_SHF_1_W, pdc_pkg::OP_SHF_CL_B, pdc_pkg::OP_SHF_CL_W: begin
				undef = (rg == pdc_pkg::SHF_REG_UNDEF);
			end
			pdc_pkg::OP_GRP3_B, pdc_pkg::OP_GRP3_W: begin
				undef = (rg == pdc_pkg::G3_REG_UNDEF);
			end
			pdc_pkg::OP_GRP4, pdc_pkg::OP_GRP5: begin
				undef = (rg == pdc_pkg::G5_REG_UNDEF);
			end
			default: begin
				undef = op inside {pdc_pkg::OP_UNDEF_0F, pdc_pkg::OP_UNDEF_F1,
					[pdc_pkg::OP_UNDEF_LO : pdc_pkg::OP_UNDEF_HI],
					[pdc_pkg::OP_ESC_FIRST : pdc_pkg::OP_ESC_LAST]};
			end
		endcase
	end

	// Load a new result when the register is free or being drained
	assign rd    = head.valid && (!out_valid_q || pop);
	assign empty = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			instr_length   <= head.rec.len;
			prefix_total   <= head.rec.prefix;
			opcode_value   <= op;
			modrm_reg      <= rg;
			is_call        <= call;
			is_uncond_jump <= ujmp;
			is_cond_jump   <= cjmp;
			is_return      <= ret;
			is_undefined   <= undef;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/x86_16_instruction_predecoder.sv -----
// Instruction predecoder for 16-bit x86-style code. Push one code byte per
// clock; the block finds instruction boundaries and, after the last byte of an
// instruction is accepted, writes its record into the record queue, moves it
// into the output register once earlier results have been popped, and offers
// one result with its length, prefix count, opcode, ModRM reg field and
// control-flow flags. It takes one byte every cycle while full is low: the
// length finder handles each byte combinationally as it is taken, and a
// four-entry record queue plus the output register absorb stalls on the result
// side. full rises only when that queue is full while the output waits to be
// popped. restart drops a partial instruction and starts a new one with the
// byte it comes with. Depends on pdc_pkg, pdc_front, pdc_fifo and pdc_back.
`default_nettype none

module x86_16_instruction_predecoder #(
	parameter int PREFIX_LIMIT = 15
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         push,
	output logic        full,
	input  wire  [7:0]  code_byte,
	input  wire         restart,
	output logic        empty,
	input  wire         pop,
	output logic [4:0]  instr_length,
	output logic [3:0]  prefix_total,
	output logic [7:0]  opcode_value,
	output logic [2:0]  modrm_reg,
	output logic        is_call,
	output logic        is_uncond_jump,
	output logic        is_cond_jump,
	output logic        is_return,
	output logic        is_undefined
);

	pdc_pkg::q_wr_t   q_wr;
	pdc_pkg::q_head_t q_head;
	logic             q_rd;
	logic             take;

	assign take = push && !full;

	pdc_front #(
		.PREFIX_LIMIT(PREFIX_LIMIT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.code_byte (code_byte),
		.restart   (restart),
		.wr        (q_wr)
	);

	pdc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.rd     (q_rd),
		.head   (q_head),
		.full   (full)
	);

	pdc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (q_head),
		.rd             (q_rd),
		.pop            (pop),
		.empty          (empty),
		.instr_length   (instr_length),
		.prefix_total   (prefix_total),
		.opcode_value   (opcode_value),
		.modrm_reg      (modrm_reg),
		.is_call        (is_call),
		.is_uncond_jump (is_uncond_jump),
		.is_cond_jump   (is_cond_jump),
		.is_return      (is_return),
		.is_undefined   (is_undefined)
	);

endmodule

`default_nettype wire

// ----- test/x86_16_instruction_predecoder_tb.sv -----
// Testbench for x86_16_instruction_predecoder: pushes code bytes, predicts each
// decoded instruction with its own byte-serial parser and checks every result.
// Depends on pdc_pkg and the predecoder RTL.

module x86_16_instruction_predecoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PREFIX_LIMIT = 15;
	localparam int ITEM_TARGET  = 750;

	localparam logic [7:0] PREFIX_BYTES [7] = '{
		pdc_pkg::PFX_LOCK, pdc_pkg::PFX_REPNE, pdc_pkg::PFX_REP, pdc_pkg::PFX_ES,
		pdc_pkg::PFX_CS, pdc_pkg::PFX_SS, pdc_pkg::PFX_DS
	};

	typedef enum logic [1:0] {AT_START, AT_MODRM, AT_TAIL} parse_phase_t;

	// One decoded instruction as seen on the result ports
	typedef struct packed {
		logic [4:0] len;
		logic [3:0] pfx;
		logic [7:0] op;
		logic [2:0] reg_f;
		logic       call;
		logic       ujmp;
		logic       cjmp;
		logic       ret;
		logic       undef;
	} decode_t;

	// Parser that predicts the decoded instructions and holds them until they pop out
	class decode_scoreboard;
		decode_t      expected_q[$];
		int           errors;
		int           prefix_limit;
		parse_phase_t phase;
		logic [3:0]   prefix_cnt;
		logic [7:0]   opcode;
		logic [7:0]   modrm;
		logic         has_modrm;
		logic [2:0]   tail_left;
		logic [4:0]   length;

		function new(int limit);
			prefix_limit = limit;
			errors = 0;
			clear_instr();
		endfunction

		function void clear_instr();
			phase = AT_START;
			prefix_cnt = '0;
			opcode = '0;
			modrm = '0;
			has_modrm = 1'b0;
			tail_left = '0;
			length = '0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Operand template: high nibble is the ModRM kind, low nibble the fixed extra bytes
		function logic [7:0] op_template(logic [7:0] op);
			case (op) inside
				[8'h00:8'h3F]: begin
					case (op[2:0])
						3'd4: return 8'd1;
						3'd5: return 8'd2;
						3'd6, 3'd7: return 8'd0;
						default: return pdc_pkg::K_M;
					endcase
				end
				8'h62: return pdc_pkg::K_M;
				8'h68: return 8'd2;
				8'h69: return pdc_pkg::K_M + 8'd2;
				8'h6A: return 8'd1;
				8'h6B: return pdc_pkg::K_M + 8'd1;
				[pdc_pkg::OP_JCC_FIRST:pdc_pkg::OP_JCC_LAST]: return 8'd1;
				[8'h80:8'h83]: return pdc_pkg::K_G1;
				[8'h84:8'h8F]: return pdc_pkg::K_M;
				pdc_pkg::OP_CALL_FAR: return 8'd4;
				[8'hA0:8'hA3]: return 8'd2;
				8'hA8: return 8'd1;
				8'hA9: return 8'd2;
				[8'hB0:8'hB7]: return 8'd1;
				[8'hB8:8'hBF]: return 8'd2;
				pdc_pkg::OP_SHF_IMM_B, pdc_pkg::OP_SHF_IMM_W, 8'hC6:
					return pdc_pkg::K_M + 8'd1;
				pdc_pkg::OP_RET_IMM, pdc_pkg::OP_RETF_IMM: return 8'd2;
				8'hC4, 8'hC5: return pdc_pkg::K_M;
				8'hC7: return pdc_pkg::K_M + 8'd2;
				8'hC8: return 8'd3;
				8'hCD: return 8'd1;
				[pdc_pkg::OP_SHF_1_B:pdc_pkg::OP_SHF_CL_W]: return pdc_pkg::K_M;
				8'hD4, 8'hD5: return 8'd1;
				[pdc_pkg::OP_LOOP_FIRST:8'hE7]: return 8'd1;
				pdc_pkg::OP_CALL_NEAR, pdc_pkg::OP_JMP_NEAR: return 8'd2;
				pdc_pkg::OP_JMP_FAR: return 8'd4;
				pdc_pkg::OP_JMP_SHORT: return 8'd1;
				pdc_pkg::OP_GRP3_B, pdc_pkg::OP_GRP3_W: return pdc_pkg::K_G3;
				pdc_pkg::OP_GRP4, pdc_pkg::OP_GRP5: return pdc_pkg::K_M;
				default: return 8'd0;
			endcase
		endfunction

		function logic needs_modrm(logic [7:0] op);
			logic [7:0] shape;
			shape = op_template(op);
			return shape[7:4] != 4'd0;
		endfunction

		// Bytes that follow the opcode, or the ModRM byte where there is one
		function logic [2:0] trailing_bytes(logic [7:0] op, logic [7:0] m);
			logic [7:0] shape;
			logic [2:0] extra;
			shape = op_template(op);
			extra = shape[2:0];
			if (shape[7:4] == 4'd0)
				return extra;
			if (m[7:6] == pdc_pkg::MOD_DISP16 ||
					(m[7:6] == pdc_pkg::MOD_MEM && m[2:0] == pdc_pkg::RM_DIRECT))
				extra += 3'd2;
			else if (m[7:6] == pdc_pkg::MOD_DISP8)
				extra += 3'd1;
			if (shape[7:4] == pdc_pkg::K_G1[7:4])
				extra += (op[1:0] == 2'b01) ? 3'd2 : 3'd1;
			else if (shape[7:4] == pdc_pkg::K_G3[7:4] && m[5:3] == pdc_pkg::G3_REG_TEST)
				extra += op[0] ? 3'd2 : 3'd1;
			return extra;
		endfunction

		// Classify the finished instruction and queue it
		function void finish_instr();
			decode_t    d;
			logic [2:0] r;
			logic       grp45;
			r = has_modrm ? modrm[5:3] : 3'd0;
			grp45 = opcode inside {pdc_pkg::OP_GRP4, pdc_pkg::OP_GRP5};
			d.len = length;
			d.pfx = prefix_cnt;
			d.op = opcode;
			d.reg_f = r;
			d.call = opcode inside {pdc_pkg::OP_CALL_FAR, pdc_pkg::OP_CALL_NEAR} ||
				(grp45 && r inside {pdc_pkg::G5_REG_CALL, pdc_pkg::G5_REG_CALLF});
			d.ret = opcode inside {pdc_pkg::OP_RET_IMM, pdc_pkg::OP_RET,
				pdc_pkg::OP_RETF_IMM, pdc_pkg::OP_RETF, pdc_pkg::OP_IRET};
			d.ujmp = d.call || d.ret || opcode inside {pdc_pkg::OP_JMP_NEAR,
				pdc_pkg::OP_JMP_FAR, pdc_pkg::OP_JMP_SHORT} ||
				(grp45 && r inside {pdc_pkg::G5_REG_JMP, pdc_pkg::G5_REG_JMPF});
			d.cjmp = opcode inside {[pdc_pkg::OP_JCC_FIRST:pdc_pkg::OP_JCC_LAST],
				[pdc_pkg::OP_LOOP_FIRST:pdc_pkg::OP_LOOP_LAST]};
			if (opcode inside {pdc_pkg::OP_UNDEF_0F, pdc_pkg::OP_UNDEF_F1,
					[pdc_pkg::OP_UNDEF_LO:pdc_pkg::OP_UNDEF_HI],
					[pdc_pkg::OP_ESC_FIRST:pdc_pkg::OP_ESC_LAST]})
				d.undef = 1'b1;
			else if (opcode inside {pdc_pkg::OP_SHF_IMM_B, pdc_pkg::OP_SHF_IMM_W,
					[pdc_pkg::OP_SHF_1_B:pdc_pkg::OP_SHF_CL_W]})
				d.undef = (r == pdc_pkg::SHF_REG_UNDEF);
			else if (opcode inside {pdc_pkg::OP_GRP3_B, pdc_pkg::OP_GRP3_W})
				d.undef = (r == pdc_pkg::G3_REG_UNDEF);
			else if (grp45)
				d.undef = (r == pdc_pkg::G5_REG_UNDEF);
			else
				d.undef = 1'b0;
			expected_q.push_back(d);
			clear_instr();
		endfunction

		function void start_tail(logic [2:0] extra);
			if (extra == 3'd0) begin
				finish_instr();
			end else begin
				tail_left = extra;
				phase = AT_TAIL;
			end
		endfunction

		// Advance the parser by one accepted item
		function void note_byte(logic [7:0] b, logic r);
			if (r)
				clear_instr();
			length++;
			case (phase)
				AT_MODRM: begin
					modrm = b;
					start_tail(trailing_bytes(opcode, b));
				end
				AT_TAIL: begin
					tail_left--;
					if (tail_left == 3'd0)
						finish_instr();
				end
				default: begin
					phase = AT_START;
					if (b inside {pdc_pkg::PFX_LOCK, pdc_pkg::PFX_REPNE, pdc_pkg::PFX_REP,
							pdc_pkg::PFX_ES, pdc_pkg::PFX_CS, pdc_pkg::PFX_SS, pdc_pkg::PFX_DS}
							&& prefix_cnt < prefix_limit) begin
						prefix_cnt++;
					end else begin
						opcode = b;
						has_modrm = needs_modrm(b);
						if (has_modrm)
							phase = AT_MODRM;
						else
							start_tail(trailing_bytes(b, 8'h00));
					end
				end
			endcase
		endfunction

		function void check_field(string name, int exp_v, int got_v);
			if (exp_v != got_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
			end
		endfunction

		// Compare a popped result with the oldest predicted instruction
		function void check_result(decode_t got);
			decode_t e;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got opcode %h length %0d",
					$time, got.op, got.len);
				return;
			end
			e = expected_q.pop_front();
			check_field("instr_length", int'(e.len), int'(got.len));
			check_field("prefix_total", int'(e.pfx), int'(got.pfx));
			check_field("opcode_value", int'(e.op), int'(got.op));
			check_field("modrm_reg", int'(e.reg_f), int'(got.reg_f));
			check_field("is_call", int'(e.call), int'(got.call));
			check_field("is_uncond_jump", int'(e.ujmp), int'(got.ujmp));
			check_field("is_cond_jump", int'(e.cjmp), int'(got.cjmp));
			check_field("is_return", int'(e.ret), int'(got.ret));
			check_field("is_undefined", int'(e.undef), int'(got.undef));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] code_byte = 8'h00;
	logic       restart = 1'b0;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	logic [4:0] instr_length;
	logic [3:0] prefix_total;
	logic [7:0] opcode_value;
	logic [2:0] modrm_reg;
	logic       is_call;
	logic       is_uncond_jump;
	logic       is_cond_jump;
	logic       is_return;
	logic       is_undefined;

	decode_scoreboard sb = new(PREFIX_LIMIT);

	int         send_idle_pct = 36;
	int         take_idle_pct = 61;
	int         sent_count = 0;
	logic [7:0] seq[$];
	logic [7:0] deck[$];

	x86_16_instruction_predecoder #(
		.PREFIX_LIMIT(PREFIX_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.code_byte(code_byte),
		.restart(restart),
		.empty(empty),
		.pop(pop),
		.instr_length(instr_length),
		.prefix_total(prefix_total),
		.opcode_value(opcode_value),
		.modrm_reg(modrm_reg),
		.is_call(is_call),
		.is_uncond_jump(is_uncond_jump),
		.is_cond_jump(is_cond_jump),
		.is_return(is_return),
		.is_undefined(is_undefined)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Hard limit on run time
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	// Watch both handshakes at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.note_byte(code_byte, restart);
			if (pop && !empty)
				sb.check_result({instr_length, prefix_total, opcode_value, modrm_reg, is_call,
					is_uncond_jump, is_cond_jump, is_return, is_undefined});
		end
	end

	// Stall the result side at random
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			pop <= ($urandom_range(99) >= take_idle_pct);
		end
	end

	// Offer one item, with random idle cycles ahead of it, and hold it until taken
	task automatic send_byte(input logic [7:0] b, input logic r);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		code_byte <= b;
		restart <= r;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sent_count++;
	endtask

	task automatic send_seq(input logic first_restart);
		foreach (seq[k])
			send_byte(seq[k], (k == 0) ? first_restart : 1'b0);
	endtask

	// Hold the input until every predicted instruction has popped out
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Refill the opcode deck with all 256 values in random order
	task automatic refill_deck();
		int         j;
		logic [7:0] t;
		deck = {};
		for (int i = 0; i < 256; i++)
			deck.push_back(i[7:0]);
		for (int i = 255; i > 0; i--) begin
			j = $urandom_range(i);
			t = deck[i];
			deck[i] = deck[j];
			deck[j] = t;
		end
	endtask

	initial begin
		int         p;
		int         n;
		int         roll;
		int         stage;
		logic [7:0] op;
		logic [7:0] m;
		logic [2:0] extra;
		logic       need_restart;

		stage = 0;
		need_restart = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Longest instruction: prefix limit, group 1 word with disp16 and imm16
		seq = {};
		for (int i = 0; i < PREFIX_LIMIT; i++)
			seq.push_back(PREFIX_BYTES[i % 7]);
		seq.push_back(8'h81);
		seq.push_back(8'hBF);
		seq.push_back(8'h00);
		seq.push_back(8'hFF);
		seq.push_back(8'h55);
		seq.push_back(8'hAA);
		send_seq(1'b0);

		// Drop a partial near call by restarting on a return
		send_byte(pdc_pkg::OP_CALL_NEAR, 1'b0);
		send_byte(pdc_pkg::OP_RET, 1'b1);

		// Byte group 4 decoded as a far call
		send_byte(pdc_pkg::OP_GRP4, 1'b0);
		send_byte(8'hD8, 1'b0);
		drain();

		refill_deck();
		while (sent_count < ITEM_TARGET) begin
			// Switch idle rates, pausing the sender until all results are out
			if (stage == 0 && sent_count >= ITEM_TARGET / 3) begin
				drain();
				send_idle_pct = 61;
				take_idle_pct = 36;
				stage = 1;
			end else if (stage == 1 && sent_count >= 2 * ITEM_TARGET / 3) begin
				drain();
				send_idle_pct = 0;
				take_idle_pct = 0;
				stage = 2;
			end

			roll = $urandom_range(99);
			if (roll < 10) begin
				// Noise: random bytes, random restarts
				n = $urandom_range(4, 1);
				for (int i = 0; i < n; i++)
					send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
				need_restart = 1'b1;
			end else begin
				// Well-formed instruction with random content
				seq = {};
				roll = $urandom_range(99);
				if (roll < 70)
					p = 0;
				else if (roll < 90)
					p = $urandom_range(3, 1);
				else if (roll < 97)
					p = $urandom_range(PREFIX_LIMIT, PREFIX_LIMIT - 2);
				else
					p = $urandom_range(PREFIX_LIMIT + 3, PREFIX_LIMIT + 1);
				for (int i = 0; i < p; i++)
					seq.push_back(PREFIX_BYTES[$urandom_range(6)]);
				op = deck.pop_front();
				if (deck.size() == 0)
					refill_deck();
				seq.push_back(op);
				m = 8'($urandom_range(255));
				if (sb.needs_modrm(op))
					seq.push_back(m);
				extra = sb.trailing_bytes(op, m);
				for (int i = 0; i < extra; i++)
					seq.push_back(8'($urandom_range(255)));
				if (p > PREFIX_LIMIT)
					need_restart = 1'b1;
				send_seq(need_restart || ($urandom_range(19) == 0));
				need_restart = (p > PREFIX_LIMIT);
				// Broken instruction: cut it short, restart the next one
				if ($urandom_range(99) < 6) begin
					seq = {};
					seq.push_back(op);
					n = $urandom_range(2);
					for (int i = 0; i < n; i++)
						seq.push_back(8'($urandom_range(255)));
					send_seq(1'b1);
					need_restart = 1'b1;
				end
			end
		end

		drain();
		repeat (16) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/pdc_pkg.sv
hw/rtl/pdc_front.sv
hw/rtl/pdc_fifo.sv
hw/rtl/pdc_back.sv
hw/rtl/x86_16_instruction_predecoder.sv
test/x86_16_instruction_predecoder_tb.sv
